// File: rtl/ssbd_pkg.sv
// Package for the dual SSB phasing demodulator: types, codes, coefficient and sine tables.
`default_nettype none
package ssbd_pkg;

  localparam int HILBERT_TAPS_DEF = 51;
  localparam int LOWPASS_TAPS_DEF = 151;
  localparam int CHANNELS_DEF     = 2;
  localparam int PHASE_BITS_DEF   = 32;

  localparam int HIL_HALF = 25;
  localparam int LP_HALF  = 75;
  localparam int QUARTER  = 256;

  localparam longint ROT_COS_Q30 = 64'sd1073721611;
  localparam longint ROT_SIN_Q30 = 64'sd6588356;

  // Register indexes on the configuration port.
  localparam logic [7:0] REG_MIX_STEP_A   = 8'd0;
  localparam logic [7:0] REG_MIX_STEP_B   = 8'd1;
  localparam logic [7:0] REG_SHIFT_STEP_A = 8'd2;
  localparam logic [7:0] REG_SHIFT_STEP_B = 8'd3;

  localparam logic [31:0] MIX_STEP_A_RST   = 32'd134217728;
  localparam logic [31:0] MIX_STEP_B_RST   = 32'd536870912;
  localparam logic [31:0] SHIFT_STEP_A_RST = 32'd107374182;
  localparam logic [31:0] SHIFT_STEP_B_RST = 32'd161061274;

  localparam int DATA_W  = 20;  // data operand of the shared multiplier
  localparam int COEF_W  = 18;  // coefficient / oscillator operand
  localparam int PROD_W  = DATA_W + COEF_W;
  localparam int ACC_W   = 48;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [15:0] sine_tab_t [0:QUARTER];

  typedef enum logic [2:0] {
    A_HIL  = 3'd0,
    A_LPRE = 3'd1,
    A_LPIM = 3'd2,
    A_RE   = 3'd3,
    A_IM   = 3'd4,
    A_YR   = 3'd5,
    A_YI   = 3'd6
  } asel_t;

  typedef struct packed {
    logic  valid;
    logic  sub;
  } mac_op_t;

  typedef struct packed {
    logic  valid;
    logic  sub;
    logic  cap;
    asel_t asel;
    coef_t coef;
  } tag_t;

  localparam coef_t HIL_MAG [0:12] = '{
    18'sd83059, 18'sd27285, 18'sd15898, 18'sd10863, 18'sd7957, 18'sd6033, 18'sd4647,
    18'sd3600, 18'sd2779, 18'sd2126, 18'sd1601, 18'sd1177, 18'sd1626};

  localparam coef_t LP_PROTO [0:75] = '{
    -18'sd45, -18'sd45, -18'sd46, -18'sd48, -18'sd49, -18'sd51, -18'sd53, -18'sd55,
    -18'sd58, -18'sd60, -18'sd62, -18'sd64, -18'sd66, -18'sd68, -18'sd68, -18'sd69,
    -18'sd68, -18'sd66, -18'sd64, -18'sd60, -18'sd54, -18'sd47, -18'sd39, -18'sd28,
    -18'sd15, 18'sd0, 18'sd17, 18'sd37, 18'sd60, 18'sd86, 18'sd114, 18'sd145,
    18'sd180, 18'sd217, 18'sd258, 18'sd302, 18'sd349, 18'sd399, 18'sd452, 18'sd508,
    18'sd567, 18'sd629, 18'sd694, 18'sd761, 18'sd831, 18'sd902, 18'sd976, 18'sd1051,
    18'sd1128, 18'sd1206, 18'sd1285, 18'sd1365, 18'sd1444, 18'sd1524, 18'sd1603,
    18'sd1682, 18'sd1760, 18'sd1836, 18'sd1910, 18'sd1983, 18'sd2053, 18'sd2120,
    18'sd2184, 18'sd2245, 18'sd2302, 18'sd2355, 18'sd2404, 18'sd2448, 18'sd2488,
    18'sd2523, 18'sd2553, 18'sd2577, 18'sd2596, 18'sd2610, 18'sd2619, 18'sd2621};

  // Quarter-wave sine in Q1.15, built by repeated rotation in Q30 at elaboration.
  function automatic sine_tab_t build_sine();
    sine_tab_t t;
    longint s;
    longint c;
    longint ns;
    longint nc;
    longint v;
    s = 64'sd0;
    c = 64'sd1073741824;
    for (int k = 0; k <= QUARTER; k++) begin
      v = (s + 64'sd16384) >>> 15;
      if (v < 64'sd0) v = 64'sd0;
      if (v > 64'sd32767) v = 64'sd32767;
      t[k] = v[15:0];
      ns = (s * ROT_COS_Q30 + c * ROT_SIN_Q30 + 64'sd536870912) >>> 30;
      nc = (c * ROT_COS_Q30 - s * ROT_SIN_Q30 + 64'sd536870912) >>> 30;
      s = ns;
      c = nc;
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  function automatic coef_t sine_at(logic [9:0] idx);
    logic [8:0]  k;
    logic [8:0]  kr;
    coef_t       v;
    coef_t       vr;
    k  = {1'b0, idx[7:0]};
    kr = 9'(QUARTER) - k;
    v  = coef_t'({2'b00, SINE_TAB[k]});
    vr = coef_t'({2'b00, SINE_TAB[kr]});
    case (idx[9:8])
      2'd0:    return v;
      2'd1:    return vr;
      2'd2:    return -v;
      default: return -vr;
    endcase
  endfunction

  function automatic coef_t hil_coef(int j, int taps);
    int d;
    int ad;
    d  = j - ((taps - 1) >>> 1);
    ad = (d < 0) ? -d : d;
    if (ad == 0 || ad > HIL_HALF || ad[0] == 1'b0) return '0;
    return (d < 0) ? -HIL_MAG[(ad - 1) >>> 1] : HIL_MAG[(ad - 1) >>> 1];
  endfunction

  function automatic coef_t lp_coef(int j, int taps);
    int d;
    int ad;
    d  = j - ((taps - 1) >>> 1);
    ad = (d < 0) ? -d : d;
    if (ad > LP_HALF) return '0;
    return LP_PROTO[LP_HALF - ad];
  endfunction

  function automatic logic signed [17:0] sat18(logic signed [ACC_W-1:0] v);
    if (v > 48'sd131071) return 18'sd131071;
    if (v < -48'sd131072) return -18'sd131072;
    return v[17:0];
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [21:0] v);
    if (v > 22'sd32767) return 16'sd32767;
    if (v < -22'sd32768) return -16'sd32768;
    return v[15:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/ssbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ssbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/ssbd_mac.sv
// Shared multiply-accumulate unit: registered product, then signed accumulation.
`default_nettype none
module ssbd_mac (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire ssbd_pkg::mac_op_t                     op,
  input  wire logic signed [ssbd_pkg::DATA_W-1:0]    a,
  input  wire ssbd_pkg::coef_t                       b,
  input  wire logic                                  clr,
  output logic signed      [ssbd_pkg::ACC_W-1:0]     acc,
  output logic                                       busy
);
  import ssbd_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic                     pv_r;
  logic                     psub_r;
  logic signed [ACC_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    psub_r <= op.sub;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      pv_r <= op.valid;
      if (clr) begin
        acc_r <= '0;
      end else if (pv_r) begin
        if (psub_r) begin
          acc_r <= acc_r - ACC_W'(prod_r);
        end else begin
          acc_r <= acc_r + ACC_W'(prod_r);
        end
      end
    end
  end

  assign acc  = acc_r;
  assign busy = pv_r;

endmodule
`default_nettype wire

// File: rtl/dual_ssb_phasing_demodulator.sv
// Top level of the dual SSB phasing demodulator: sequencer, state and shared MAC.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------------
//  input   | in_valid / in_ready  | in_sample_in
//  output  | out_valid/ out_ready | out_channel_a_out, out_channel_b_out, out_mixed_byte
//  config  | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// Every product of a sample passes through the single shared multiplier, fed one product
// a cycle while a run issues. After reset both delay-line memories are cleared, over
// max(HILBERT_TAPS, CHANNELS * LOWPASS_TAPS) addresses, before the first sample is taken.
// A held result stalls the sequencer only at its final step; in_ready is high only when idle.
`default_nettype none
module dual_ssb_phasing_demodulator #(
  parameter int HILBERT_TAPS = ssbd_pkg::HILBERT_TAPS_DEF,
  parameter int LOWPASS_TAPS = ssbd_pkg::LOWPASS_TAPS_DEF,
  parameter int CHANNELS     = ssbd_pkg::CHANNELS_DEF,
  parameter int PHASE_BITS   = ssbd_pkg::PHASE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_sample_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed      [15:0] out_channel_a_out,
  output logic signed      [15:0] out_channel_b_out,
  output logic signed      [7:0]  out_mixed_byte,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [7:0]  cfg_index,
  input  wire logic        [31:0] cfg_data
);
  import ssbd_pkg::*;

  localparam int HAW  = $clog2(HILBERT_TAPS);
  localparam int LIW  = $clog2(LOWPASS_TAPS);
  localparam int LPD  = CHANNELS * LOWPASS_TAPS;
  localparam int LAW  = $clog2(LPD);
  localparam int CHW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MAXN = (HILBERT_TAPS > LOWPASS_TAPS) ? HILBERT_TAPS : LOWPASS_TAPS;
  localparam int CW   = $clog2(MAXN + 1);
  localparam int CLRN = (HILBERT_TAPS > LPD) ? HILBERT_TAPS : LPD;
  localparam int CLW  = $clog2(CLRN + 1);
  localparam int PB   = PHASE_BITS;

  typedef enum logic [9:0] {
    ST_CLEAR = 10'b0000000001,
    ST_IDLE  = 10'b0000000010,
    ST_HIL   = 10'b0000000100,
    ST_MIXR  = 10'b0000001000,
    ST_MIXI  = 10'b0000010000,
    ST_LPR   = 10'b0000100000,
    ST_LPI   = 10'b0001000000,
    ST_UP    = 10'b0010000000,
    ST_DONE  = 10'b0100000000,
    ST_SPARE = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [CLW-1:0] clr_r, clr_nxt;
  logic [HAW-1:0] hpos_r, hpos_nxt, haddr_r, haddr_nxt;
  logic [LIW-1:0] pos_r, pos_nxt, lidx_r, lidx_nxt;
  logic [LAW-1:0] base_r, base_nxt;
  logic [CHW-1:0] ch_r, ch_nxt;

  logic [PB-1:0] mix_ph_r [CHANNELS];
  logic [PB-1:0] sh_ph_r  [CHANNELS];
  logic [PB-1:0] mix_step_a_r, mix_step_b_r, shift_step_a_r, shift_step_b_r;

  logic signed [15:0]       re_r;
  logic signed [17:0]       im_r, im_nxt, lr_r, lr_nxt;
  logic signed [DATA_W-1:0] yr_r, yr_nxt, yi_r, yi_nxt;
  logic signed [DATA_W-1:0] real_a_r, real_a_nxt, real_b_r, real_b_nxt;
  logic signed [21:0]       total_r, total_nxt;

  logic              out_valid_r;
  logic signed [15:0] out_a_r, out_b_r;
  logic signed [7:0]  out_m_r;
  logic signed [15:0] mix_sat;

  tag_t tag_nxt, tag1_r;

  // Memories.
  logic             hil_we;
  logic [HAW-1:0]   hil_waddr;
  logic [15:0]      hil_wdata, hil_rdata;
  logic             lp_we;
  logic [LAW-1:0]   lp_waddr, lp_raddr;
  logic [35:0]      lp_wdata, lp_rdata;

  ssbd_ram #(.WIDTH(16), .DEPTH(HILBERT_TAPS)) u_hil_ram (
    .clk   (clk),
    .we    (hil_we),
    .waddr (hil_waddr),
    .wdata (hil_wdata),
    .raddr (haddr_r),
    .rdata (hil_rdata)
  );

  ssbd_ram #(.WIDTH(36), .DEPTH(LPD)) u_lp_ram (
    .clk   (clk),
    .we    (lp_we),
    .waddr (lp_waddr),
    .wdata (lp_wdata),
    .raddr (lp_raddr),
    .rdata (lp_rdata)
  );

  assign lp_raddr = base_r + LAW'(lidx_r);

  // Shared MAC.
  mac_op_t                  mop;
  logic signed [DATA_W-1:0] mac_a;
  logic signed [ACC_W-1:0]  acc;
  logic                     mac_busy;
  logic                     mac_clr;

  assign mop.valid = tag1_r.valid;
  assign mop.sub   = tag1_r.sub;

  always_comb begin
    case (tag1_r.asel)
      A_HIL:   mac_a = DATA_W'(signed'(hil_rdata));
      A_LPRE:  mac_a = DATA_W'(signed'(lp_rdata[35:18]));
      A_LPIM:  mac_a = DATA_W'(signed'(lp_rdata[17:0]));
      A_RE:    mac_a = DATA_W'(re_r);
      A_IM:    mac_a = DATA_W'(im_r);
      A_YR:    mac_a = yr_r;
      A_YI:    mac_a = yi_r;
      default: mac_a = '0;
    endcase
  end

  ssbd_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (mop),
    .a     (mac_a),
    .b     (tag1_r.coef),
    .clr   (mac_clr),
    .acc   (acc),
    .busy  (mac_busy)
  );

  logic signed [ACC_W-1:0] rnd15, rnd17;
  assign rnd15 = (acc + 48'sd16384) >>> 15;
  assign rnd17 = (acc + 48'sd65536) >>> 17;

  // Oscillator for the current channel.
  logic [PB-1:0] osc_ph;
  coef_t         osc_c, osc_s;
  assign osc_ph = (state_r == ST_UP) ? sh_ph_r[ch_r] : mix_ph_r[ch_r];
  assign osc_s  = sine_at(osc_ph[PB-1 -: 10]);
  assign osc_c  = sine_at(osc_ph[PB-1 -: 10] + 10'd256);

  logic [CW-1:0] run_len;
  logic          issue, run_done, out_free;
  logic signed [DATA_W-1:0] up_real;

  assign up_real  = rnd15[DATA_W-1:0];
  assign out_free = !out_valid_r || out_ready;
  assign mix_sat  = sat16(total_r);

  always_comb begin
    case (state_r)
      ST_HIL:  run_len = CW'(HILBERT_TAPS);
      ST_LPR:  run_len = CW'(LOWPASS_TAPS);
      ST_LPI:  run_len = CW'(LOWPASS_TAPS);
      default: run_len = CW'(2);
    endcase
  end

  assign issue = (state_r == ST_HIL || state_r == ST_MIXR || state_r == ST_MIXI ||
                  state_r == ST_LPR || state_r == ST_LPI || state_r == ST_UP) &&
                 (cnt_r < run_len);
  assign run_done = (cnt_r == run_len) && !tag1_r.valid && !mac_busy;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = issue ? cnt_r + CW'(1) : cnt_r;
    clr_nxt    = clr_r;
    hpos_nxt   = hpos_r;
    haddr_nxt  = haddr_r;
    pos_nxt    = pos_r;
    lidx_nxt   = lidx_r;
    base_nxt   = base_r;
    ch_nxt     = ch_r;
    im_nxt     = im_r;
    lr_nxt     = lr_r;
    yr_nxt     = yr_r;
    yi_nxt     = yi_r;
    real_a_nxt = real_a_r;
    real_b_nxt = real_b_r;
    total_nxt  = total_r;
    mac_clr    = 1'b0;
    hil_we     = 1'b0;
    hil_waddr  = hpos_r;
    hil_wdata  = in_sample_in;
    lp_we      = 1'b0;
    lp_waddr   = base_r + LAW'(pos_r);
    lp_wdata   = {lr_r, sat18(rnd15)};
    tag_nxt       = '0;
    tag_nxt.valid = issue;
    tag_nxt.asel  = A_HIL;

    case (state_r)
      ST_CLEAR: begin
        hil_we    = clr_r < CLW'(HILBERT_TAPS);
        hil_waddr = clr_r[HAW-1:0];
        hil_wdata = '0;
        lp_we     = clr_r < CLW'(LPD);
        lp_waddr  = clr_r[LAW-1:0];
        lp_wdata  = '0;
        clr_nxt   = clr_r + CLW'(1);
        if (clr_r == CLW'(CLRN - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          hil_we     = 1'b1;
          haddr_nxt  = hpos_r;
          cnt_nxt    = '0;
          ch_nxt     = '0;
          base_nxt   = '0;
          lidx_nxt   = pos_r;
          real_a_nxt = '0;
          real_b_nxt = '0;
          total_nxt  = '0;
          state_nxt  = ST_HIL;
        end
      end
      ST_HIL: begin
        tag_nxt.asel = A_HIL;
        tag_nxt.coef = hil_coef(int'(cnt_r), HILBERT_TAPS);
        tag_nxt.cap  = (cnt_r == CW'((HILBERT_TAPS - 1) >>> 1));
        if (issue) begin
          haddr_nxt = (haddr_r == '0) ? HAW'(HILBERT_TAPS - 1) : haddr_r - HAW'(1);
        end
        if (run_done) begin
          im_nxt    = rnd17[17:0];
          mac_clr   = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_MIXR;
        end
      end
      ST_MIXR: begin
        tag_nxt.asel = (cnt_r == '0) ? A_RE : A_IM;
        tag_nxt.coef = (cnt_r == '0) ? osc_c : osc_s;
        if (run_done) begin
          lr_nxt    = sat18(rnd15);
          mac_clr   = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_MIXI;
        end
      end
      ST_MIXI: begin
        // im*cos - re*sin
        tag_nxt.asel = (cnt_r == '0) ? A_IM : A_RE;
        tag_nxt.coef = (cnt_r == '0) ? osc_c : osc_s;
        tag_nxt.sub  = (cnt_r != '0);
        if (run_done) begin
          lp_we     = 1'b1;
          mac_clr   = 1'b1;
          cnt_nxt   = '0;
          lidx_nxt  = pos_r;
          state_nxt = ST_LPR;
        end
      end
      ST_LPR, ST_LPI: begin
        tag_nxt.asel = (state_r == ST_LPR) ? A_LPRE : A_LPIM;
        tag_nxt.coef = lp_coef(int'(cnt_r), LOWPASS_TAPS);
        if (issue) begin
          lidx_nxt = (lidx_r == '0) ? LIW'(LOWPASS_TAPS - 1) : lidx_r - LIW'(1);
        end
        if (run_done) begin
          mac_clr  = 1'b1;
          cnt_nxt  = '0;
          lidx_nxt = pos_r;
          if (state_r == ST_LPR) begin
            yr_nxt    = rnd17[DATA_W-1:0];
            state_nxt = ST_LPI;
          end else begin
            yi_nxt    = rnd17[DATA_W-1:0];
            state_nxt = ST_UP;
          end
        end
      end
      ST_UP: begin
        tag_nxt.asel = (cnt_r == '0) ? A_YR : A_YI;
        tag_nxt.coef = (cnt_r == '0) ? osc_c : osc_s;
        tag_nxt.sub  = (cnt_r != '0);
        if (run_done) begin
          mac_clr   = 1'b1;
          cnt_nxt   = '0;
          total_nxt = total_r + 22'(up_real);
          if (ch_r == '0) real_a_nxt = up_real;
          if (ch_r == CHW'(1)) real_b_nxt = up_real;
          if (ch_r == CHW'(CHANNELS - 1)) begin
            state_nxt = ST_DONE;
          end else begin
            ch_nxt    = ch_r + CHW'(1);
            base_nxt  = base_r + LAW'(LOWPASS_TAPS);
            lidx_nxt  = pos_r;
            state_nxt = ST_MIXR;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          pos_nxt   = (pos_r == LIW'(LOWPASS_TAPS - 1)) ? '0 : pos_r + LIW'(1);
          hpos_nxt  = (hpos_r == HAW'(HILBERT_TAPS - 1)) ? '0 : hpos_r + HAW'(1);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      cnt_r          <= '0;
      clr_r          <= '0;
      hpos_r         <= '0;
      haddr_r        <= '0;
      pos_r          <= '0;
      lidx_r         <= '0;
      base_r         <= '0;
      ch_r           <= '0;
      tag1_r         <= '0;
      out_valid_r    <= 1'b0;
      mix_step_a_r   <= MIX_STEP_A_RST[PB-1:0];
      mix_step_b_r   <= MIX_STEP_B_RST[PB-1:0];
      shift_step_a_r <= SHIFT_STEP_A_RST[PB-1:0];
      shift_step_b_r <= SHIFT_STEP_B_RST[PB-1:0];
      for (int c = 0; c < CHANNELS; c++) begin
        mix_ph_r[c] <= '0;
        sh_ph_r[c]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      clr_r   <= clr_nxt;
      hpos_r  <= hpos_nxt;
      haddr_r <= haddr_nxt;
      pos_r   <= pos_nxt;
      lidx_r  <= lidx_nxt;
      base_r  <= base_nxt;
      ch_r    <= ch_nxt;
      tag1_r  <= tag_nxt;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
        for (int c = 0; c < CHANNELS; c++) begin
          mix_ph_r[c] <= mix_ph_r[c] + (c[0] ? mix_step_b_r : mix_step_a_r);
          sh_ph_r[c]  <= sh_ph_r[c] + (c[0] ? shift_step_b_r : shift_step_a_r);
        end
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_MIX_STEP_A:   mix_step_a_r   <= cfg_data[PB-1:0];
          REG_MIX_STEP_B:   mix_step_b_r   <= cfg_data[PB-1:0];
          REG_SHIFT_STEP_A: shift_step_a_r <= cfg_data[PB-1:0];
          REG_SHIFT_STEP_B: shift_step_b_r <= cfg_data[PB-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    im_r     <= im_nxt;
    lr_r     <= lr_nxt;
    yr_r     <= yr_nxt;
    yi_r     <= yi_nxt;
    real_a_r <= real_a_nxt;
    real_b_r <= real_b_nxt;
    total_r  <= total_nxt;
    // The centre tap of the window is the in-phase part.
    if (tag1_r.valid && tag1_r.cap) begin
      re_r <= hil_rdata;
    end
    if (state_r == ST_DONE && out_free) begin
      out_a_r <= sat16(22'(real_a_r));
      out_b_r <= sat16(22'(real_b_r));
      out_m_r <= mix_sat[15:8];
    end
  end

  assign in_ready          = (state_r == ST_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_channel_a_out = out_a_r;
  assign out_channel_b_out = out_b_r;
  assign out_mixed_byte    = out_m_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a sample is in progress");

  a_pipe_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !tag1_r.valid && !mac_busy)
    else $error("MAC pipeline not empty while idle");

  a_ring_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r < LIW'(LOWPASS_TAPS)) && (lidx_r < LIW'(LOWPASS_TAPS)) &&
    (hpos_r < HAW'(HILBERT_TAPS)))
    else $error("ring index out of range");

  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside the final step");

endmodule
`default_nettype wire

// File: sim/dual_ssb_phasing_demodulator_tb.sv
// Testbench for the dual SSB phasing demodulator: predictor, scoreboard class and stimulus.
`timescale 1ns / 100ps
`default_nettype none
module dual_ssb_phasing_demodulator_tb;
  import ssbd_pkg::*;

  localparam int HT = 51;
  localparam int LT = 151;
  localparam int HCTR = 25;
  localparam int LCTR = 75;
  localparam int LAT = 2000;

  typedef struct packed {
    logic signed [15:0] chan_a;
    logic signed [15:0] chan_b;
    logic signed [7:0]  mixed;
  } demod_res_t;

  // Predictor state.
  longint      sine_q[0:256];
  longint      hil_win[0:HT-1];
  longint      lp_re[0:1][0:LT-1];
  longint      lp_im[0:1][0:LT-1];
  int          wr_pos;
  logic [31:0] mix_acc[0:1];
  logic [31:0] shf_acc[0:1];
  logic [31:0] mix_inc[0:1];
  logic [31:0] shf_inc[0:1];
  longint      hil_tap[0:HT-1];
  longint      lp_tap[0:LT-1];

  function automatic longint fl_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shr(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint table_sine(int idx);
    int k;
    k = idx & 255;
    case ((idx >> 8) & 3)
      0: return sine_q[k];
      1: return sine_q[256 - k];
      2: return -sine_q[k];
      default: return -sine_q[256 - k];
    endcase
  endfunction

  task automatic setup_tables();
    longint s, c, ns, nc;
    int d, ad;
    longint mags[0:12];
    longint proto[0:75];
    mags = '{83059, 27285, 15898, 10863, 7957, 6033, 4647, 3600, 2779, 2126, 1601,
             1177, 1626};
    proto = '{-45, -45, -46, -48, -49, -51, -53, -55, -58, -60, -62, -64, -66, -68, -68,
              -69, -68, -66, -64, -60, -54, -47, -39, -28, -15, 0, 17, 37, 60, 86, 114,
              145, 180, 217, 258, 302, 349, 399, 452, 508, 567, 629, 694, 761, 831, 902,
              976, 1051, 1128, 1206, 1285, 1365, 1444, 1524, 1603, 1682, 1760, 1836,
              1910, 1983, 2053, 2120, 2184, 2245, 2302, 2355, 2404, 2448, 2488, 2523,
              2553, 2577, 2596, 2610, 2619, 2621};
    s = 0;
    c = longint'(1) <<< 30;
    for (int k = 0; k <= 256; k++) begin
      sine_q[k] = clip(rnd_shr(s, 15), 0, 32767);
      ns = rnd_shr(s * 1073721611 + c * 6588356, 30);
      nc = rnd_shr(c * 1073721611 - s * 6588356, 30);
      s = ns;
      c = nc;
    end
    for (int j = 0; j < HT; j++) begin
      d = j - HCTR;
      ad = d < 0 ? -d : d;
      if (ad == 0 || ad > 25 || (ad & 1) == 0) hil_tap[j] = 0;
      else hil_tap[j] = d < 0 ? -mags[(ad - 1) / 2] : mags[(ad - 1) / 2];
    end
    for (int j = 0; j < LT; j++) begin
      d = j - LCTR;
      ad = d < 0 ? -d : d;
      lp_tap[j] = proto[LCTR - ad];
    end
  endtask

  task automatic clear_state();
    for (int j = 0; j < HT; j++) hil_win[j] = 0;
    for (int c = 0; c < 2; c++) begin
      for (int j = 0; j < LT; j++) begin
        lp_re[c][j] = 0;
        lp_im[c][j] = 0;
      end
      mix_acc[c] = '0;
      shf_acc[c] = '0;
    end
    wr_pos = 0;
    mix_inc[0] = MIX_STEP_A_RST;
    mix_inc[1] = MIX_STEP_B_RST;
    shf_inc[0] = SHIFT_STEP_A_RST;
    shf_inc[1] = SHIFT_STEP_B_RST;
  endtask

  function automatic demod_res_t demodulate(logic signed [15:0] smp);
    demod_res_t r;
    longint acc, im, re, cv, sv, ar, ai, yr, yi, real_part, total;
    longint chan_real[0:1];
    int idx, ph;
    for (int j = HT - 1; j > 0; j--) hil_win[j] = hil_win[j-1];
    hil_win[0] = smp;
    acc = 0;
    for (int j = 0; j < HT; j++) acc += hil_win[j] * hil_tap[j];
    im = rnd_shr(acc, 17);
    re = hil_win[HCTR];
    total = 0;
    for (int c = 0; c < 2; c++) begin
      ph = int'(mix_acc[c][31:22]);
      sv = table_sine(ph);
      cv = table_sine((ph + 256) & 1023);
      lp_re[c][wr_pos] = clip(rnd_shr(re * cv + im * sv, 15), -131072, 131071);
      lp_im[c][wr_pos] = clip(rnd_shr(im * cv - re * sv, 15), -131072, 131071);
      ar = 0;
      ai = 0;
      for (int j = 0; j < LT; j++) begin
        idx = wr_pos - j;
        if (idx < 0) idx += LT;
        ar += lp_re[c][idx] * lp_tap[j];
        ai += lp_im[c][idx] * lp_tap[j];
      end
      yr = rnd_shr(ar, 17);
      yi = rnd_shr(ai, 17);
      ph = int'(shf_acc[c][31:22]);
      sv = table_sine(ph);
      cv = table_sine((ph + 256) & 1023);
      real_part = rnd_shr(yr * cv - yi * sv, 15);
      chan_real[c] = real_part;
      total += real_part;
    end
    r.chan_a = 16'(clip(chan_real[0], -32768, 32767));
    r.chan_b = 16'(clip(chan_real[1], -32768, 32767));
    r.mixed = 8'(fl_shr(clip(total, -32768, 32767), 8));
    wr_pos = (wr_pos + 1 >= LT) ? 0 : wr_pos + 1;
    for (int c = 0; c < 2; c++) begin
      mix_acc[c] = mix_acc[c] + mix_inc[c];
      shf_acc[c] = shf_acc[c] + shf_inc[c];
    end
    return r;
  endfunction

  class demod_scoreboard;
    demod_res_t pending[$];
    int         errors;

    function void note_sample(demod_res_t exp_res);
      pending.push_back(exp_res);
    endfunction

    function void check_result(demod_res_t got);
      demod_res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result a=%0d b=%0d m=%0d",
                                   got.chan_a, got.chan_b, got.mixed);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected a=%0d b=%0d m=%0d, got a=%0d b=%0d m=%0d",
                   want.chan_a, want.chan_b, want.mixed, got.chan_a, got.chan_b, got.mixed);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_sample_in;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_channel_a_out;
  logic signed [15:0] out_channel_b_out;
  logic signed [7:0]  out_mixed_byte;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [7:0]         cfg_index;
  logic [31:0]        cfg_data;

  demod_scoreboard sb;
  bit              calm;

  dual_ssb_phasing_demodulator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample_in(in_sample_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_channel_a_out(out_channel_a_out), .out_channel_b_out(out_channel_b_out),
    .out_mixed_byte(out_mixed_byte),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #80ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MIX_STEP_A:   mix_inc[0] = val;
      REG_MIX_STEP_B:   mix_inc[1] = val;
      REG_SHIFT_STEP_A: shf_inc[0] = val;
      REG_SHIFT_STEP_B: shf_inc[1] = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_sample(logic signed [15:0] smp);
    if (!calm && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 16)) @(posedge clk);
    in_valid <= 1'b1;
    in_sample_in <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
    sb.note_sample(demodulate(smp));
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
  endtask

  task automatic program_all(logic [31:0] ma, logic [31:0] mb, logic [31:0] sa,
                             logic [31:0] sbv);
    write_reg(REG_MIX_STEP_A, ma);
    write_reg(REG_MIX_STEP_B, mb);
    write_reg(REG_SHIFT_STEP_A, sa);
    write_reg(REG_SHIFT_STEP_B, sbv);
  endtask

  // Loud, quiet and full-scale material, so that both saturations are visited.
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
      1: return 16'($urandom_range(0, 255)) - 16'sd128;
      default: return 16'($urandom());
    endcase
  endfunction

  // Result side: accept with random stalls.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_channel_a_out, out_channel_b_out, out_mixed_byte});
  end

  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  initial begin
    logic signed [15:0] dir[0:11];
    sb = new();
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_in = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    setup_tables();
    clear_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Impulses and full-scale steps at the reset settings.
    dir = '{16'sh7fff, 0, 0, -16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff, 1, -1,
            16'sh5555, -16'sh5556, 0};
    foreach (dir[i]) send_sample(dir[i]);
    drain();
    // Extremes of the steps, and an index outside the register map.
    program_all(32'h0, 32'hffff_ffff, 32'hffff_ffff, 32'h0);
    write_reg(8'd200, 32'h1234_5678);
    for (int i = 0; i < 12; i++) send_sample(i[0] ? 16'sh7fff : -16'sh8000);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      program_all($urandom(), $urandom(), $urandom(), $urandom());
      if (phase == 4) calm = 1'b1;
      for (int i = 0; i < 112; i++) send_sample(pick_sample());
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
